// ----- rtl/core/ipd_pkg.sv -----
// Package with the shared types and constants of the isolated pixel detector.
`default_nettype none

package ipd_pkg;

  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 16;
  localparam int HEIGHT_W    = 16;
  localparam int WIDTH_CFG_W = 11;

  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 1'b1;

  typedef struct packed {
    logic uns;
    logic set;
  } flags_t;

  typedef struct packed {
    logic row_zero;
    logic last_col;
    logic last_row;
    logic single;
  } item_ctl_t;

endpackage

`default_nettype wire

// ----- rtl/core/ipd_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
`default_nettype none

module ipd_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 1024
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic                                   re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/ipd_seq.sv -----
// Configuration registers and raster position counters of the detector.
`default_nettype none

module ipd_seq #(
  parameter int MAX_WIDTH = 1024,
  parameter int AW        = 10,
  parameter int WW        = 11
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_we,
  input  wire logic [ipd_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  wire logic [ipd_pkg::CFG_DATA_W-1:0]       cfg_wdata,
  input  wire logic                                 accept,
  output logic      [AW-1:0]                        col,
  output ipd_pkg::item_ctl_t                        ctl
);

  import ipd_pkg::*;

  localparam int CW = (WW > WIDTH_CFG_W) ? WW : WIDTH_CFG_W;

  logic [HEIGHT_W-1:0]    image_height;
  logic [WIDTH_CFG_W-1:0] image_width;
  logic [HEIGHT_W-1:0]    row_count;
  logic [AW-1:0]          column_count;
  logic [HEIGHT_W-1:0]    height_eff;
  logic [CW-1:0]          width_ext;
  logic [CW-1:0]          width_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_height <= HEIGHT_W'(1);
      image_width  <= WIDTH_CFG_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IMAGE_HEIGHT: image_height <= cfg_wdata[HEIGHT_W-1:0];
        REG_IMAGE_WIDTH:  image_width  <= cfg_wdata[WIDTH_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    height_eff = (image_height == '0) ? HEIGHT_W'(1) : image_height;
    width_ext  = CW'(image_width);
    if (width_ext == '0) begin
      width_eff = CW'(1);
    end else if (width_ext > CW'(MAX_WIDTH)) begin
      width_eff = CW'(MAX_WIDTH);
    end else begin
      width_eff = width_ext;
    end
    col          = column_count;
    ctl.row_zero = (row_count == '0);
    ctl.last_col = ((CW+1)'(column_count) + (CW+1)'(1)) >= (CW+1)'(width_eff);
    ctl.last_row = ((HEIGHT_W+1)'(row_count) + (HEIGHT_W+1)'(1)) >=
                   (HEIGHT_W+1)'(height_eff);
    ctl.single   = (height_eff == HEIGHT_W'(1)) && (width_eff == CW'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count    <= '0;
      column_count <= '0;
    end else if (accept) begin
      if (ctl.last_col) begin
        column_count <= '0;
        row_count    <= ctl.last_row ? '0 : row_count + HEIGHT_W'(1);
      end else begin
        column_count <= column_count + AW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/ipd_settle.sv -----
// Read-modify-write stage that settles pixels against the column memory.
`default_nettype none

module ipd_settle #(
  parameter int AW = 10
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 accept,
  input  wire logic                 pix,
  input  wire logic [AW-1:0]        col,
  input  ipd_pkg::item_ctl_t        ctl,
  input  ipd_pkg::flags_t           rd_flags,
  output logic                      wr_en,
  output logic      [AW-1:0]        wr_addr,
  output ipd_pkg::flags_t           wr_flags,
  output logic                      hold,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic                      isolated_found
);

  import ipd_pkg::*;

  logic      b_valid;
  logic      b_pix;
  logic [AW-1:0] b_col;
  item_ctl_t b_ctl;
  logic      fwd_hit;
  flags_t    fwd_flags;
  logic      pend_valid;
  logic [AW-1:0] pend_col;
  flags_t    pend_flags;
  logic      left_set;
  logic      left_uns;
  logic      failure_seen;

  logic      advance;
  flags_t    above;
  logic      lu;
  logic      cur_uns;
  logic      fail_next;
  logic      fwd_hit_next;
  flags_t    fwd_flags_next;

  always_comb begin
    hold    = b_valid && b_ctl.last_col && b_ctl.last_row && out_valid && out_stall;
    advance = b_valid && !hold;
    if (b_ctl.row_zero) begin
      above = '0;
    end else if (fwd_hit) begin
      above = fwd_flags;
    end else begin
      above = rd_flags;
    end
    lu        = left_uns && !b_pix;
    cur_uns   = b_pix && !above.set && !left_set;
    fail_next = failure_seen || (above.uns && !b_pix) ||
                ((b_col != '0) && b_ctl.last_row && lu) ||
                (b_ctl.last_col && b_ctl.last_row && cur_uns);

    if (b_col != '0) begin
      wr_en    = advance;
      wr_addr  = b_col - AW'(1);
      wr_flags = '{uns: lu, set: left_set};
    end else begin
      wr_en    = advance && pend_valid;
      wr_addr  = pend_col;
      wr_flags = pend_flags;
    end

    if (advance && b_ctl.last_col && (b_col == col)) begin
      fwd_hit_next   = 1'b1;
      fwd_flags_next = '{uns: cur_uns, set: b_pix};
    end else if (advance && (b_col != '0) && (b_col - AW'(1) == col)) begin
      fwd_hit_next   = 1'b1;
      fwd_flags_next = '{uns: lu, set: left_set};
    end else if (pend_valid && (pend_col == col)) begin
      fwd_hit_next   = 1'b1;
      fwd_flags_next = pend_flags;
    end else begin
      fwd_hit_next   = 1'b0;
      fwd_flags_next = pend_flags;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      b_pix     <= pix;
      b_col     <= col;
      b_ctl     <= ctl;
      fwd_hit   <= fwd_hit_next;
      fwd_flags <= fwd_flags_next;
    end
    if (advance && b_ctl.last_col) begin
      pend_col   <= b_col;
      pend_flags <= '{uns: cur_uns, set: b_pix};
    end
    if (advance && b_ctl.last_col && b_ctl.last_row) begin
      isolated_found <= fail_next || b_ctl.single;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid      <= 1'b0;
      pend_valid   <= 1'b0;
      left_set     <= 1'b0;
      left_uns     <= 1'b0;
      failure_seen <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (accept) begin
        b_valid <= 1'b1;
      end else if (advance) begin
        b_valid <= 1'b0;
      end

      if (advance) begin
        if (b_ctl.last_col) begin
          pend_valid   <= 1'b1;
          left_set     <= 1'b0;
          left_uns     <= 1'b0;
          failure_seen <= b_ctl.last_row ? 1'b0 : fail_next;
        end else begin
          if (b_col == '0) begin
            pend_valid <= 1'b0;
          end
          left_set     <= b_pix;
          left_uns     <= cur_uns;
          failure_seen <= fail_next;
        end
      end

      if (advance && b_ctl.last_col && b_ctl.last_row) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/isolated_pixel_detector_top.sv -----
// Top level of the isolated pixel detector for raster binary images.
//
//   channel  signals                         direction  content
//   in       in_valid, in_stall, pixel_set   input      one pixel per transaction
//   out      out_valid, out_stall,           output     one verdict per image
//            isolated_found
//   cfg      cfg_we, cfg_index, cfg_wdata    input      image_height, image_width
//
// One pixel is taken per cycle unless the input stalls: the column memory is
// read when a pixel is accepted and written back by the settle stage when
// the following pixel advances through it. The verdict is registered: the
// last pixel passes the settle stage register, then the output register.
// Input stalls only while a verdict waits in the output register and the
// settle stage holds the next image's last pixel.
// Reset is synchronous; the column memory is not cleared, as the first row
// of every image never uses its contents.
`default_nettype none

module isolated_pixel_detector_top #(
  parameter int MAX_WIDTH = 1024
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [ipd_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [ipd_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic                             pixel_set,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic                                  isolated_found
);

  import ipd_pkg::*;

  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WW = $clog2(MAX_WIDTH + 1);

  logic          accept;
  logic [AW-1:0] col;
  item_ctl_t     ctl;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  flags_t        wr_flags;
  flags_t        rd_flags;

  assign accept = in_valid && !in_stall;

  ipd_seq #(
    .MAX_WIDTH (MAX_WIDTH),
    .AW        (AW),
    .WW        (WW)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .accept    (accept),
    .col       (col),
    .ctl       (ctl)
  );

  ipd_ram #(
    .WIDTH ($bits(flags_t)),
    .DEPTH (MAX_WIDTH)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_flags),
    .re    (accept),
    .raddr (col),
    .rdata (rd_flags)
  );

  ipd_settle #(
    .AW (AW)
  ) u_settle (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .pix            (pixel_set),
    .col            (col),
    .ctl            (ctl),
    .rd_flags       (rd_flags),
    .wr_en          (wr_en),
    .wr_addr        (wr_addr),
    .wr_flags       (wr_flags),
    .hold           (in_stall),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .isolated_found (isolated_found)
  );

`ifndef NO_ASSERTIONS
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("Input stalled while the output register could take a verdict.");

  a_row_wraps: assert property (@(posedge clk) disable iff (rst)
    (accept && ctl.last_col) |=> (col == '0))
    else $error("Column counter did not return to zero after the last column.");

  a_col_steps: assert property (@(posedge clk) disable iff (rst)
    (accept && !ctl.last_col) |=> (col == AW'($past(col) + AW'(1))))
    else $error("Column counter did not advance by one after an inner pixel.");
`endif

endmodule

`default_nettype wire
